FILE: src/assert_macros.svh
// Assertion macros shared by the draw engine RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_n_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("assertion failed");
`endif

FILE: src/fbde_pkg.sv
// Shared constants, opcodes and types for the frame buffer draw engine.
// No dependencies.
package fbde_pkg;
	localparam int DefScreenWidth  = 240;
	localparam int DefScreenHeight = 320;
	localparam int CoordW  = 10;
	localparam int ColorW  = 16;
	localparam int OpW     = 3;
	localparam int GlyphWW = 5;
	localparam logic [GlyphWW-1:0] GlyphMsbLimit = 5'd12;
	localparam logic [GlyphWW-1:0] GlyphResetW   = 5'd16;
	localparam logic [ColorW-1:0]  TextResetColor = 16'hFFFF;

	localparam logic [OpW-1:0] OP_PIXEL  = 3'd0;
	localparam logic [OpW-1:0] OP_HLINE  = 3'd1;
	localparam logic [OpW-1:0] OP_VLINE  = 3'd2;
	localparam logic [OpW-1:0] OP_BOX    = 3'd3;
	localparam logic [OpW-1:0] OP_CIRCLE = 3'd4;
	localparam logic [OpW-1:0] OP_CLEAR  = 3'd5;
	localparam logic [OpW-1:0] OP_GLYPH  = 3'd6;
	localparam logic [OpW-1:0] OP_READ   = 3'd7;

	localparam logic REG_TEXT_COLOR  = 1'b0;
	localparam logic REG_GLYPH_WIDTH = 1'b1;

	// Pixel write or read request toward the frame store.
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [ColorW-1:0] color;
	} px_req_t;
endpackage

FILE: src/fbde_store.sv
// Frame store: one synchronous memory with a registered read, one pixel
// port. The engine writes every entry after reset and on a clear.
// Depends on fbde_pkg.
module fbde_store #(
	parameter int SCREEN_WIDTH  = fbde_pkg::DefScreenWidth,
	parameter int SCREEN_HEIGHT = fbde_pkg::DefScreenHeight
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fbde_pkg::px_req_t         req,
	output logic [fbde_pkg::ColorW-1:0] rd_data
);
	import fbde_pkg::*;
	`include "assert_macros.svh"

	localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AddrW = $clog2(Depth);

	logic [ColorW-1:0] mem_color [Depth];
	logic [ColorW-1:0] rd_color_q;
	logic [AddrW-1:0]  addr;
	logic [2*AddrW-1:0] prod;

	assign prod = AddrW'(req.y) * AddrW'(SCREEN_WIDTH);
	assign addr = AddrW'(prod) + AddrW'(req.x);

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_color[addr] <= req.color;
		end
		rd_color_q <= mem_color[addr];
	end

	assign rd_data = rd_color_q;

	`ASSERT_IMPL(a_no_rw_clash, clk, arst_n, !(req.wr && req.rd))
	`ASSERT_IMPL(a_x_in_range, clk, arst_n, (req.wr || req.rd) |-> ({1'b0, req.x} < (CoordW+1)'(SCREEN_WIDTH)))
	`ASSERT_IMPL(a_y_in_range, clk, arst_n, (req.wr || req.rd) |-> ({1'b0, req.y} < (CoordW+1)'(SCREEN_HEIGHT)))
endmodule

FILE: src/framebuffer_draw_engine.sv
// Frame buffer draw engine: a sequencer that walks each command's pixels
// and drives the frame store. Depends on fbde_pkg and fbde_store.
//
// Usage:
//  - Commands arrive on the in_valid/in_ready channel, one item per command.
//    Each command yields exactly one result item on out_valid/out_ready.
//  - Pixel, line, box, circle and glyph commands step one pixel position
//    per cycle over their area; a zero length or zero glyph width still
//    passes through the walk state but writes nothing.
//  - Clear writes draw_color to every entry, one pixel a cycle.
//  - Read pixel does one store read, whose data the store registers; a
//    read outside the screen skips the store and reports out_of_screen.
//  - The sequencer's single store port sets the rate: one pixel per cycle.
//  - After reset a clearing pass writes zero to every entry, one pixel a
//    cycle; no command is accepted meanwhile. Configuration writes are
//    taken always.
//  - The result sits in an output register; a new command is accepted while
//    it waits, but its own result waits until the old one is taken.
module framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = fbde_pkg::DefScreenWidth,
	parameter int SCREEN_HEIGHT = fbde_pkg::DefScreenHeight
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fbde_pkg::OpW-1:0]          opcode,
	input  logic [fbde_pkg::CoordW-1:0]       x_pos,
	input  logic [fbde_pkg::CoordW-1:0]       y_pos,
	input  logic [fbde_pkg::CoordW-1:0]       size_main,
	input  logic [fbde_pkg::CoordW-1:0]       size_second,
	input  logic [fbde_pkg::ColorW-1:0]       draw_color,
	input  logic [fbde_pkg::ColorW-1:0]       fill_color,
	input  logic [fbde_pkg::ColorW-1:0]       glyph_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fbde_pkg::ColorW-1:0]       pixel_value,
	output logic                              out_of_screen,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [fbde_pkg::ColorW-1:0]       cfg_data
);
	import fbde_pkg::*;
	`include "assert_macros.svh"

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;
	localparam logic [2:0] ST_FILL = 3'd6;

	// Signed offset width: spans -2048..2047.
	localparam int OffW = CoordW + 2;
	localparam int SqW  = 2 * OffW;

	logic [2:0]          state_q;
	logic [OpW-1:0]      op_q;
	logic [CoordW-1:0]   x_q, y_q, sm_q, ss_q;
	logic [ColorW-1:0]   dc_q, fc_q, gr_q;
	logic [ColorW-1:0]   text_color_q;
	logic [GlyphWW-1:0]  glyph_width_q;
	logic signed [OffW-1:0] i_q, j_q;       // column and row offset
	logic [SqW-1:0]      rr_q;
	logic [CoordW-1:0]   ix_q, iy_q;        // init and clear sweep
	logic                res_oos_q;
	logic [ColorW-1:0]   res_val_q;
	logic                out_valid_q;
	logic [ColorW-1:0]   out_val_q;
	logic                out_oos_q;

	px_req_t             req;
	logic [ColorW-1:0]   rd_data;

	fbde_store #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_store (
		.clk(clk), .arst_n(arst_n), .req(req), .rd_data(rd_data)
	);

	// Walk bounds per op: i from i_lo..i_hi, j from j_lo..j_hi.
	logic signed [OffW-1:0] i_lo, i_hi, j_lo, j_hi;
	logic signed [OffW-1:0] px, py;
	logic                   hit, on_screen;
	logic [ColorW-1:0]      color;
	logic [SqW-1:0]         dd;
	logic [3:0]             bit_idx;
	logic signed [OffW-1:0] sm_s, ss_s;
	logic                   last_i, last_j, empty;

	assign sm_s = OffW'($signed({2'b0, sm_q}));
	assign ss_s = OffW'($signed({2'b0, ss_q}));

	always_comb begin
		i_lo = '0; i_hi = '0; j_lo = '0; j_hi = '0; empty = 1'b0;
		case (op_q)
			OP_HLINE: begin i_hi = sm_s - OffW'(1); empty = (sm_q == '0); end
			OP_VLINE: begin j_hi = sm_s - OffW'(1); empty = (sm_q == '0); end
			OP_BOX: begin i_hi = sm_s; j_hi = ss_s; end
			OP_CIRCLE: begin i_lo = -sm_s; i_hi = sm_s; j_lo = -sm_s; j_hi = sm_s; end
			OP_GLYPH: begin
				i_hi = OffW'($signed({1'b0, glyph_width_q})) - OffW'(1);
				empty = (glyph_width_q == '0);
			end
			default: ;
		endcase
	end

	assign last_i = (i_q == i_hi);
	assign last_j = (j_q == j_hi);
	assign px = OffW'($signed({2'b0, x_q})) + i_q;
	assign py = OffW'($signed({2'b0, y_q})) + j_q;
	assign on_screen = !px[OffW-1] && !py[OffW-1]
		&& (px < OffW'(SCREEN_WIDTH)) && (py < OffW'(SCREEN_HEIGHT));
	assign dd = SqW'(i_q * i_q) + SqW'(j_q * j_q);

	always_comb begin
		hit = 1'b0;
		color = dc_q;
		bit_idx = '0;
		case (op_q)
			OP_HLINE, OP_VLINE, OP_PIXEL: hit = 1'b1;
			OP_BOX: begin
				// Border lines, except the far corner; interior gets fill.
				if (i_q == sm_s && j_q == ss_s) hit = 1'b0;
				else if ((j_q == '0 || j_q == ss_s) && i_q != sm_s) hit = 1'b1;
				else if ((i_q == '0 || i_q == sm_s) && j_q != ss_s) hit = 1'b1;
				else begin hit = 1'b1; color = fc_q; end
			end
			OP_CIRCLE: hit = (dd <= rr_q);
			OP_GLYPH: begin
				color = text_color_q;
				if (glyph_width_q < GlyphMsbLimit)
					hit = (i_q < OffW'(8)) && gr_q[3'd7 - i_q[2:0]];
				else if (glyph_width_q == GlyphMsbLimit)
					hit = gr_q[4'd15 - i_q[3:0]];
				else begin
					bit_idx = i_q[3:0];
					hit = (i_q < OffW'(16)) && gr_q[bit_idx];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_INIT, ST_FILL: begin
				req.wr = 1'b1; req.x = ix_q; req.y = iy_q;
				req.color = (state_q == ST_FILL) ? dc_q : '0;
			end
			ST_WALK: begin
				if (!empty && hit && on_screen) begin
					req.wr = 1'b1; req.x = px[CoordW-1:0]; req.y = py[CoordW-1:0];
					req.color = color;
				end
			end
			ST_RD: begin req.rd = 1'b1; req.x = x_q; req.y = y_q; end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= opcode; x_q <= x_pos; y_q <= y_pos; sm_q <= size_main;
			ss_q <= size_second; dc_q <= draw_color; fc_q <= fill_color;
			gr_q <= glyph_row;
			rr_q <= SqW'(size_main) * SqW'(size_main);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q  <= TextResetColor;
			glyph_width_q <= GlyphResetW;
		end else if (cfg_we) begin
			if (cfg_index == REG_TEXT_COLOR) text_color_q <= cfg_data;
			else glyph_width_q <= cfg_data[GlyphWW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ix_q <= '0; iy_q <= '0; i_q <= '0; j_q <= '0;
			res_oos_q <= 1'b0; res_val_q <= '0;
			out_valid_q <= 1'b0; out_val_q <= '0; out_oos_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_FILL: begin
					if (ix_q == CoordW'(SCREEN_WIDTH - 1)) begin
						ix_q <= '0;
						if (iy_q == CoordW'(SCREEN_HEIGHT - 1)) begin
							iy_q <= '0;
							state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
						end else iy_q <= iy_q + 1'b1;
					end else ix_q <= ix_q + 1'b1;
				end
				ST_IDLE: if (in_valid) begin
					res_oos_q <= 1'b0; res_val_q <= '0;
					if (opcode == OP_READ) begin
						if ({1'b0, x_pos} >= (CoordW+1)'(SCREEN_WIDTH)
								|| {1'b0, y_pos} >= (CoordW+1)'(SCREEN_HEIGHT)) begin
							res_oos_q <= 1'b1; state_q <= ST_DONE;
						end else state_q <= ST_RD;
					end else if (opcode == OP_CLEAR) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_WALK;
						if (opcode == OP_CIRCLE) begin
							i_q <= -OffW'(size_main); j_q <= -OffW'(size_main);
						end else begin i_q <= '0; j_q <= '0; end
					end
				end
				ST_WALK: begin
					if (empty || op_q == OP_PIXEL) state_q <= ST_DONE;
					else if (last_i) begin
						i_q <= i_lo;
						if (last_j) state_q <= ST_DONE;
						else j_q <= j_q + 1'b1;
					end else i_q <= i_q + 1'b1;
				end
				ST_RD: state_q <= ST_RES;
				ST_RES: begin res_val_q <= rd_data; state_q <= ST_DONE; end
				ST_DONE: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1; out_val_q <= res_val_q; out_oos_q <= res_oos_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_value   = out_val_q;
	assign out_of_screen = out_oos_q;

	`ASSERT_IMPL(a_oos_zero, clk, arst_n, out_valid |-> !(out_of_screen && pixel_value != '0))
	`ASSERT_IMPL(a_wr_on_screen, clk, arst_n, req.wr |-> ({1'b0, req.x} < (CoordW+1)'(SCREEN_WIDTH)))
	`ASSERT_IMPL(a_done_next, clk, arst_n, (state_q == ST_RD) |=> (state_q == ST_RES))
endmodule
